>>> sv/cisr_pkg.sv
// ----------------------------------------------------------------------------
// cisr_pkg
// Shared types and constants of the case-insensitive substring search core.
// ----------------------------------------------------------------------------
package cisr_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int PATTERN_BYTES   = 16;
	localparam int LEN_W           = 5;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 5;
	localparam int REG_SEL_LSB     = 3;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [PATTERN_BYTES*8-1:0] pattern;
		logic [LEN_W-1:0]           pattern_length;
	} search_cfg_t;

endpackage

>>> sv/cisr_text_if.sv
// ----------------------------------------------------------------------------
// cisr_text_if
// Channel that carries message bytes into the search core.
// ----------------------------------------------------------------------------
interface cisr_text_if;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_message;

	modport source (output valid, output text_byte, output end_of_message, input ready);
	modport sink   (input valid, input text_byte, input end_of_message, output ready);

endinterface

>>> sv/cisr_result_if.sv
// ----------------------------------------------------------------------------
// cisr_result_if
// Channel that carries one search result per finished message.
// ----------------------------------------------------------------------------
interface cisr_result_if;

	logic valid;
	logic ready;
	logic found;

	modport source (output valid, output found, input ready);
	modport sink   (input valid, input found, output ready);

endinterface

>>> sv/case_insensitive_substring_search_core.sv
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_core
// Reports per message whether a configured pattern occurs, ignoring letter case.
// ----------------------------------------------------------------------------
// Message bytes arrive on the text channel, one item per cycle, with the last
// byte of each message marked by end_of_message. The result channel carries
// one item per message whose found bit tells whether the pattern of 1 to 16
// bytes occurred anywhere in it. The pattern and its length are written over
// the APB port while the core is idle.
// An accepted byte enters the window register at once; the compare of the
// window against the pattern runs in the following cycle and, for the last
// byte, lands in the result register. A result is valid once the result register
// has taken it, and the core sustains one byte per cycle.
// The result register decouples the two channels: bytes keep flowing while a
// result waits. Only when a second result is ready while the first is still
// held does text.ready drop, until the receiver takes the held result.
// Reset clears the window, the fill count, the found flag and the pattern
// registers, with the pattern length set to one.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_core #(
	parameter int MAX_PATTERN = cisr_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cisr_text_if.sink                       text,
	cisr_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cisr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cisr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cisr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import cisr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	search_cfg_t                 cfg;
	logic [MAX_PATTERN-1:0][7:0] window_s1;
	logic [CNT_W-1:0]            count_s1;
	logic                        valid_s1;
	logic                        eom_s1;
	logic                        hit;
	logic                        advance;
	logic                        accept;
	logic                        match_seen_q;
	logic                        out_valid_q;
	logic                        found_q;

	cisr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cisr_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.text_byte      (text.text_byte),
		.end_of_message (text.end_of_message),
		.window_s1      (window_s1),
		.count_s1       (count_s1)
	);

	cisr_compare #(.MAX_PATTERN(MAX_PATTERN)) u_compare (
		.window_s1 (window_s1),
		.count_s1  (count_s1),
		.cfg       (cfg),
		.hit       (hit)
	);

	// The stage holds only when its item needs the result register and that is full and not being taken.
	assign advance    = !(valid_s1 && eom_s1 && out_valid_q && !result.ready);
	assign accept     = text.valid && advance;
	assign text.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			eom_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= text.valid;
			eom_s1   <= text.end_of_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (advance && valid_s1) begin
				match_seen_q <= eom_s1 ? 1'b0 : (match_seen_q || hit);
			end
			if (advance && valid_s1 && eom_s1) begin
				out_valid_q <= 1'b1;
				found_q     <= match_seen_q || hit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.found = found_q;

endmodule

>>> sv/cisr_apb_regs.sv
// ----------------------------------------------------------------------------
// cisr_apb_regs
// APB register file holding the search pattern and its length.
// ----------------------------------------------------------------------------
module cisr_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cisr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cisr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cisr_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output cisr_pkg::search_cfg_t          cfg
);
	import cisr_pkg::*;

	logic [APB_DATA_W-1:0] pattern_low_q;
	logic [APB_DATA_W-1:0] pattern_high_q;
	logic [LEN_W-1:0]      pattern_length_q;
	logic                  wr_en;
	reg_index_t            sel;

	assign sel    = reg_index_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (wr_en) begin
			case (sel)
				REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
				REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_PATTERN_LOW:    prdata = pattern_low_q;
			REG_PATTERN_HIGH:   prdata = pattern_high_q;
			REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.pattern        = {pattern_high_q, pattern_low_q};
	assign cfg.pattern_length = pattern_length_q;

endmodule

>>> sv/cisr_window.sv
// ----------------------------------------------------------------------------
// cisr_window
// Window of the most recent message bytes and a saturating fill count.
// ----------------------------------------------------------------------------
module cisr_window #(
	parameter int MAX_PATTERN = cisr_pkg::MAX_PATTERN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [7:0]                           text_byte,
	input  logic                                 end_of_message,
	output logic [MAX_PATTERN-1:0][7:0]          window_s1,
	output logic [$clog2(MAX_PATTERN+1)-1:0]     count_s1
);
	import cisr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic                         restart_q;
	logic [MAX_PATTERN-1:0][7:0]  window_next;
	logic [CNT_W-1:0]             count_next;

	// A new message starts with an empty window.
	always_comb begin
		window_next[0] = text_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			window_next[i] = restart_q ? 8'h00 : window_s1[i-1];
		end
		if (restart_q) begin
			count_next = CNT_W'(1);
		end else if (count_s1 < CNT_W'(MAX_PATTERN)) begin
			count_next = count_s1 + CNT_W'(1);
		end else begin
			count_next = count_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_s1 <= '0;
			count_s1  <= '0;
			restart_q <= 1'b0;
		end else if (accept) begin
			window_s1 <= window_next;
			count_s1  <= count_next;
			restart_q <= end_of_message;
		end
	end

endmodule

>>> sv/cisr_compare.sv
// ----------------------------------------------------------------------------
// cisr_compare
// Parallel case-folded compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
module cisr_compare #(
	parameter int MAX_PATTERN = cisr_pkg::MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN-1:0][7:0]      window_s1,
	input  logic [$clog2(MAX_PATTERN+1)-1:0] count_s1,
	input  cisr_pkg::search_cfg_t            cfg,
	output logic                             hit
);
	import cisr_pkg::*;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	logic [LEN_W-1:0]       eff_len;
	logic [MAX_PATTERN-1:0] byte_ok;
	logic [7:0]             w_sel [MAX_PATTERN];

	always_comb begin
		if (cfg.pattern_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = cfg.pattern_length;
		end
	end

	// Pattern byte p lines up with the byte received eff_len-1-p steps ago.
	always_comb begin
		for (int p = 0; p < MAX_PATTERN; p++) begin
			w_sel[p] = 8'h00;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (LEN_W'(i) == eff_len - LEN_W'(1) - LEN_W'(p)) begin
					w_sel[p] = window_s1[i];
				end
			end
			byte_ok[p] = (LEN_W'(p) >= eff_len) ||
				(fold_case(w_sel[p]) == fold_case(cfg.pattern[p*8 +: 8]));
		end
	end

	assign hit = (LEN_W'(count_s1) >= eff_len) && (&byte_ok);

endmodule
